>>> hdl/md5bs_pkg.sv
// ----------------------------------------------------------------------------
// MD5 byte stream hasher package
// Request types, sequencer states, round constants and round helper functions.
// ----------------------------------------------------------------------------
package md5bs_pkg;

    localparam logic [1:0] CMD_START  = 2'd0;
    localparam logic [1:0] CMD_FEED   = 2'd1;
    localparam logic [1:0] CMD_FINISH = 2'd2;

    localparam logic [7:0] PAD_BYTE = 8'h80;

    typedef struct packed {
        logic [1:0] command;
        logic [7:0] data_byte;
    } t_in;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [1:0]  word_index;
        logic        last_word;
    } t_out;

    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        logic [31:0] d;
    } t_abcd;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_ROUND,
        ST_ADD,
        ST_OUT
    } t_state;

    typedef enum logic [1:0] {
        PAD_MARK,
        PAD_ZERO,
        PAD_LEN
    } t_pad;

    localparam logic [31:0] H_INIT [4] = '{
        32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476
    };

    localparam logic [31:0] K_TAB [64] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };

    localparam logic [4:0] ROT_TAB [16] = '{
        5'd7, 5'd12, 5'd17, 5'd22,
        5'd5, 5'd9,  5'd14, 5'd20,
        5'd4, 5'd11, 5'd16, 5'd23,
        5'd6, 5'd10, 5'd15, 5'd21
    };

    function automatic logic [3:0] msg_idx(input logic [5:0] rnd);
        logic [3:0] j;
        logic [3:0] g;
        j = rnd[3:0];
        case (rnd[5:4])
            2'd0:    g = j;
            2'd1:    g = 4'(j * 4'd5 + 4'd1);
            2'd2:    g = 4'(j * 4'd3 + 4'd5);
            default: g = 4'(j * 4'd7);
        endcase
        return g;
    endfunction

    function automatic logic [31:0] rotl32(input logic [31:0] v, input logic [4:0] s);
        logic [63:0] w;
        w = {v, v} << s;
        return w[63:32];
    endfunction

endpackage

>>> hdl/md5bs_round.sv
// ----------------------------------------------------------------------------
// MD5 round unit
// One compression round: boolean function, sum with the precomputed
// constant plus message word, rotate and final add.
// ----------------------------------------------------------------------------
module md5bs_round
    import md5bs_pkg::*;
(
    input  t_abcd       i_cur,
    input  logic [31:0] i_km,
    input  logic [5:0]  i_rnd,
    output t_abcd       o_nxt
);

    logic [31:0] f;
    logic [31:0] t;
    logic [31:0] rot;

    always_comb begin
        case (i_rnd[5:4])
            2'd0:    f = i_cur.d ^ (i_cur.b & (i_cur.c ^ i_cur.d));
            2'd1:    f = i_cur.c ^ (i_cur.d & (i_cur.b ^ i_cur.c));
            2'd2:    f = i_cur.b ^ i_cur.c ^ i_cur.d;
            default: f = i_cur.c ^ (i_cur.b | ~i_cur.d);
        endcase
        t       = i_cur.a + f + i_km;
        rot     = rotl32(t, ROT_TAB[{i_rnd[5:4], i_rnd[1:0]}]);
        o_nxt.a = i_cur.d;
        o_nxt.b = i_cur.b + rot;
        o_nxt.c = i_cur.b;
        o_nxt.d = i_cur.c;
    end

endmodule

>>> hdl/md5_byte_stream_hasher.sv
// ----------------------------------------------------------------------------
// MD5 byte stream hasher
// Packs bytes into a 16-word block, runs the 64-round compression on a
// shared round unit, pads on finish and returns the four digest words.
// ----------------------------------------------------------------------------
//  channel | direction | handshake        | payload
//  input   | in        | i_valid/o_stall  | i_data  (command, data_byte)
//  output  | out       | o_valid/i_stall  | o_data  (digest_word, word_index, last_word)
//
//  A feed that fills the block starts compression: 64 rounds on the single
//  round unit, then the chaining add.
//  Finish pads one byte a cycle while not compressing, pausing once at byte 56,
//  compresses once or twice, then shows four digest words, one per cycle that
//  is not stalled.
//  Reset loads the initial chaining words and clears block, position, count.
//  Input is stalled whenever the sequencer is not idle.
// ----------------------------------------------------------------------------
module md5_byte_stream_hasher
    import md5bs_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_stall,
    input  t_in  i_data,
    output logic o_valid,
    input  logic i_stall,
    output t_out o_data
);

    t_state      r_state;
    t_state      n_state;
    t_state      r_ret;
    t_pad        r_pad;
    logic [31:0] r_h [4];
    logic [31:0] r_blk [16];
    logic [5:0]  r_pos;
    logic [63:0] r_cnt;
    logic [63:0] r_len;
    logic [2:0]  r_len_idx;
    logic [5:0]  r_rnd;
    logic [31:0] r_km;
    t_abcd       r_abcd;
    logic [1:0]  r_out_idx;

    t_abcd       rnd_nxt;
    logic [5:0]  rnd_inc;
    logic        in_acc;
    logic        ld_en;
    logic [7:0]  ld_byte;
    logic        go_round;
    logic        out_done;
    logic        clr_msg;
    t_state      ret_sel;

    md5bs_round u_round (
        .i_cur (r_abcd),
        .i_km  (r_km),
        .i_rnd (r_rnd),
        .o_nxt (rnd_nxt)
    );

    assign in_acc   = i_valid && !o_stall;
    assign rnd_inc  = 6'(r_rnd + 6'd1);
    assign go_round = ld_en && (r_pos == 6'd63);
    assign out_done = (r_state == ST_OUT) && !i_stall && (r_out_idx == 2'd3);
    assign clr_msg  = (in_acc && (i_data.command == CMD_START)) || out_done;

    always_comb begin
        ld_en   = 1'b0;
        ld_byte = 8'd0;
        if (r_state == ST_IDLE) begin
            ld_en   = in_acc && (i_data.command == CMD_FEED);
            ld_byte = i_data.data_byte;
        end else if (r_state == ST_PAD) begin
            case (r_pad)
                PAD_MARK: begin
                    ld_en   = 1'b1;
                    ld_byte = PAD_BYTE;
                end
                PAD_ZERO: begin
                    ld_en   = (r_pos != 6'd56);
                    ld_byte = 8'd0;
                end
                default: begin
                    ld_en   = 1'b1;
                    ld_byte = r_len[7:0];
                end
            endcase
        end
        if (r_state == ST_IDLE) begin
            ret_sel = ST_IDLE;
        end else if ((r_pad == PAD_LEN) && (r_len_idx == 3'd7)) begin
            ret_sel = ST_OUT;
        end else begin
            ret_sel = ST_PAD;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (go_round) begin
                    n_state = ST_ROUND;
                end else if (in_acc && (i_data.command == CMD_FINISH)) begin
                    n_state = ST_PAD;
                end
            end
            ST_PAD: begin
                if (go_round) begin
                    n_state = ST_ROUND;
                end
            end
            ST_ROUND: begin
                if (r_rnd == 6'd63) begin
                    n_state = ST_ADD;
                end
            end
            ST_ADD: begin
                n_state = r_ret;
            end
            ST_OUT: begin
                if (out_done) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_stall            = (r_state != ST_IDLE);
        o_valid            = (r_state == ST_OUT);
        o_data.digest_word = r_h[r_out_idx];
        o_data.word_index  = r_out_idx;
        o_data.last_word   = (r_out_idx == 2'd3);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || clr_msg) begin
            r_h       <= H_INIT;
            r_blk     <= '{default: '0};
            r_pos     <= '0;
            r_cnt     <= '0;
            r_pad     <= PAD_MARK;
            r_len_idx <= '0;
            r_out_idx <= '0;
            r_ret     <= ST_IDLE;
        end else begin
            if (ld_en) begin
                r_blk[r_pos[5:2]][{r_pos[1:0], 3'b000} +: 8] <= ld_byte;
                r_pos <= 6'(r_pos + 6'd1);
            end
            if (in_acc && (i_data.command == CMD_FEED)) begin
                r_cnt <= r_cnt + 64'd8;
            end
            if (in_acc && (i_data.command == CMD_FINISH)) begin
                r_len     <= r_cnt;
                r_pad     <= PAD_MARK;
                r_len_idx <= '0;
            end
            if (r_state == ST_PAD) begin
                case (r_pad)
                    PAD_MARK: r_pad <= PAD_ZERO;
                    PAD_ZERO: begin
                        if (r_pos == 6'd56) begin
                            r_pad <= PAD_LEN;
                        end
                    end
                    default: begin
                        r_len     <= r_len >> 8;
                        r_len_idx <= 3'(r_len_idx + 3'd1);
                    end
                endcase
            end
            if (go_round) begin
                r_ret  <= ret_sel;
                r_abcd <= '{a: r_h[0], b: r_h[1], c: r_h[2], d: r_h[3]};
                r_rnd  <= '0;
                r_km   <= K_TAB[0] + r_blk[0];
            end
            if (r_state == ST_ROUND) begin
                r_abcd <= rnd_nxt;
                r_rnd  <= rnd_inc;
                r_km   <= K_TAB[rnd_inc] + r_blk[msg_idx(rnd_inc)];
            end
            if (r_state == ST_ADD) begin
                r_h[0] <= r_h[0] + r_abcd.a;
                r_h[1] <= r_h[1] + r_abcd.b;
                r_h[2] <= r_h[2] + r_abcd.c;
                r_h[3] <= r_h[3] + r_abcd.d;
                r_blk  <= '{default: '0};
            end
            if ((r_state == ST_OUT) && !i_stall) begin
                r_out_idx <= 2'(r_out_idx + 2'd1);
            end
        end
    end

    a_round_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ROUND && r_rnd != 6'd63)
        |=> (r_state == ST_ROUND && r_rnd == 6'($past(r_rnd) + 6'd1)))
        else $error("round counter did not advance");

    a_full_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_data.command == CMD_FEED && r_pos == 6'd63)
        |=> (r_state == ST_ROUND && r_rnd == 6'd0 && r_pos == 6'd0))
        else $error("full block did not start compression");

    a_len_tail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_PAD && r_pad == PAD_LEN) |-> (r_pos[5:3] == 3'd7))
        else $error("length bytes outside the block tail");

    a_digest_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall && o_data.last_word)
        |=> (r_state == ST_IDLE && r_pos == 6'd0 && r_cnt == 64'd0))
        else $error("state not restarted after digest");

endmodule

>>> tb/tb_md5_byte_stream_hasher.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MD5 byte stream hasher testbench
// Streams start, feed, finish and unused requests with random gaps and output
// stalls, predicts every digest word with an in-bench MD5 and checks each word.
// ----------------------------------------------------------------------------
module tb_md5_byte_stream_hasher;
    import md5bs_pkg::*;

    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int IDLE_LIMIT = 5000;
    localparam int RANDOM_REQUESTS = 500;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_stall;
    t_in  i_data = '0;
    logic o_valid;
    logic i_stall = 1'b0;
    t_out o_data;

    logic [31:0] round_k [64];
    int unsigned rot_amt [16];
    logic [31:0] chain [4];
    logic [31:0] msg_block [16];
    logic [5:0]  byte_pos;
    logic [63:0] bit_len;

    t_in  pending_requests [$];
    t_out digest_q [$];
    int gap_left = 0;
    int stall_left = 0;
    int quiet_cycles = 0;
    int idle_cycles = 0;
    int n_bad = 0;
    int n_random = 0;

    md5_byte_stream_hasher u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (o_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [31:0] rol32(input logic [31:0] v, input int unsigned s);
        return (v << s) | (v >> (32 - s));
    endfunction

    task automatic md5_restart();
        chain[0] = 32'h67452301;
        chain[1] = 32'hefcdab89;
        chain[2] = 32'h98badcfe;
        chain[3] = 32'h10325476;
        for (int w = 0; w < 16; w++) msg_block[w] = '0;
        byte_pos = '0;
        bit_len = '0;
    endtask

    task automatic md5_compress();
        logic [31:0] a, b, c, d, f, t;
        int g;
        a = chain[0];
        b = chain[1];
        c = chain[2];
        d = chain[3];
        for (int i = 0; i < 64; i++) begin
            case (i / 16)
                0: begin
                    f = (b & c) | (~b & d);
                    g = i;
                end
                1: begin
                    f = (b & d) | (c & ~d);
                    g = (5 * i + 1) % 16;
                end
                2: begin
                    f = b ^ c ^ d;
                    g = (3 * i + 5) % 16;
                end
                default: begin
                    f = c ^ (b | ~d);
                    g = (7 * i) % 16;
                end
            endcase
            t = a + f + msg_block[g] + round_k[i];
            a = d;
            d = c;
            c = b;
            b = b + rol32(t, rot_amt[(i / 16) * 4 + i % 4]);
        end
        chain[0] += a;
        chain[1] += b;
        chain[2] += c;
        chain[3] += d;
    endtask

    task automatic md5_take_byte(input logic [7:0] v);
        msg_block[byte_pos[5:2]][8 * byte_pos[1:0] +: 8] = v;
        if (byte_pos == 6'd63) begin
            md5_compress();
            for (int w = 0; w < 16; w++) msg_block[w] = '0;
        end
        byte_pos = byte_pos + 6'd1;
    endtask

    task automatic md5_absorb(input t_in req);
        logic [63:0] len;
        t_out word;
        case (req.command)
            CMD_START: md5_restart();
            CMD_FEED: begin
                md5_take_byte(req.data_byte);
                bit_len = bit_len + 64'd8;
            end
            CMD_FINISH: begin
                len = bit_len;
                md5_take_byte(8'h80);
                while (byte_pos != 6'd56) md5_take_byte(8'h00);
                for (int k = 0; k < 8; k++) md5_take_byte(len[8 * k +: 8]);
                for (int k = 0; k < 4; k++) begin
                    word.digest_word = chain[k];
                    word.word_index = 2'(k);
                    word.last_word = (k == 3);
                    digest_q.push_back(word);
                end
                md5_restart();
            end
            default: ;
        endcase
    endtask

    function automatic int pick_gap();
        int r;
        if (quiet_cycles > 0) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic int random_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return $urandom_range(0, 20);
        if (r < 85) return $urandom_range(50, 70);
        if (r < 95) return $urandom_range(110, 135);
        return $urandom_range(180, 300);
    endfunction

    task automatic push_request(input logic [1:0] cmd, input logic [7:0] data);
        t_in req;
        req.command = cmd;
        req.data_byte = data;
        pending_requests.push_back(req);
        if (cmd != CMD_UNUSED) n_random++;
    endtask

    task automatic queue_message(input int n_bytes);
        if ($urandom_range(0, 4) != 0) push_request(CMD_START, 8'($urandom));
        for (int n = 0; n < n_bytes; n++) begin
            if ($urandom_range(0, 29) == 0) push_request(CMD_UNUSED, 8'($urandom));
            if ($urandom_range(0, 99) == 0) push_request(CMD_START, 8'($urandom));
            push_request(CMD_FEED, 8'($urandom));
        end
        if ($urandom_range(0, 9) != 0) push_request(CMD_FINISH, 8'($urandom));
    endtask

    task automatic note_mismatch(input string what, input logic [31:0] exp_v,
                                 input logic [31:0] got_v);
        if (n_bad < 10) $display("%0t mismatch %s: expected %h, got %h", $time, what, exp_v, got_v);
        n_bad++;
    endtask

    initial begin
        real s;
        for (int i = 0; i < 64; i++) begin
            s = $sin(i + 1);
            if (s < 0.0) s = -s;
            round_k[i] = 32'(longint'($floor(s * 4294967296.0)));
        end
        rot_amt = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21};
        md5_restart();

        push_request(CMD_FINISH, 8'h00);
        push_request(CMD_START, 8'hff);
        push_request(CMD_FINISH, 8'h00);
        push_request(CMD_FEED, 8'h61);
        push_request(CMD_FEED, 8'h62);
        push_request(CMD_FEED, 8'h63);
        push_request(CMD_FINISH, 8'hff);
        push_request(CMD_START, 8'h00);
        push_request(CMD_FEED, 8'h00);
        push_request(CMD_FEED, 8'hff);
        push_request(CMD_UNUSED, 8'hff);
        push_request(CMD_UNUSED, 8'h00);
        push_request(CMD_FEED, 8'h80);
        push_request(CMD_FINISH, 8'h55);
        push_request(CMD_START, 8'haa);
        push_request(CMD_START, 8'h01);
        push_request(CMD_FEED, 8'h7f);
        push_request(CMD_FINISH, 8'h00);

        n_random = 0;
        queue_message(55);
        queue_message(56);
        queue_message(63);
        queue_message(64);
        while (n_random < RANDOM_REQUESTS) queue_message(random_length());

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (pending_requests.size() != 0 || i_valid) @(negedge i_clk);
        while (digest_q.size() != 0) @(negedge i_clk);
        repeat (200) @(posedge i_clk);
        if (n_bad == 0 && digest_q.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            gap_left <= 0;
        end else if (!i_valid || !o_stall) begin
            if (i_valid) md5_absorb(i_data);
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                i_valid <= 1'b0;
            end else if (pending_requests.size() != 0) begin
                i_data <= pending_requests.pop_front();
                i_valid <= 1'b1;
                gap_left <= pick_gap();
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        t_out want;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
            stall_left <= 0;
        end else begin
            if (o_valid && !i_stall) begin
                if (digest_q.size() == 0) begin
                    note_mismatch("digest word with none pending", '0, o_data.digest_word);
                end else begin
                    want = digest_q.pop_front();
                    if (o_data.digest_word !== want.digest_word)
                        note_mismatch("digest_word", want.digest_word, o_data.digest_word);
                    if (o_data.word_index !== want.word_index)
                        note_mismatch("word_index", 32'(want.word_index), 32'(o_data.word_index));
                    if (o_data.last_word !== want.last_word)
                        note_mismatch("last_word", 32'(want.last_word), 32'(o_data.last_word));
                end
            end
            if (stall_left > 0) begin
                i_stall <= 1'b1;
                stall_left <= stall_left - 1;
            end else begin
                i_stall <= 1'b0;
                stall_left <= ($urandom_range(0, 2) == 0) ? pick_gap() : 0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (quiet_cycles > 0) begin
            quiet_cycles <= quiet_cycles - 1;
        end else if ($urandom_range(0, 499) == 0) begin
            quiet_cycles <= $urandom_range(100, 300);
        end
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule

>>> files.f
hdl/md5bs_pkg.sv
hdl/md5bs_round.sv
hdl/md5_byte_stream_hasher.sv
tb/tb_md5_byte_stream_hasher.sv
